// ===== rtl/dcmf_pkg.sv =====
// Dark channel min filter: shared types, codes and default sizes.
// No dependencies; used by dcmf_if, dcmf_scan and the top level.
package dcmf_pkg;

    localparam int PATCH_DEF      = 15;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [PIX_W-1:0] PIX_MAX   = 8'hFF;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_top_state;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_READ,
        SC_LAST,
        SC_FIN
    } t_scan_state;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] value;
    } t_scan_stat;

endpackage

// ===== rtl/dcmf_if.sv =====
// Valid/ready channel interfaces for pixel requests and dark channel results.
// Depends on dcmf_pkg for the channel width.
interface dcmf_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [dcmf_pkg::PIX_W-1:0]  red;
    logic [dcmf_pkg::PIX_W-1:0]  green;
    logic [dcmf_pkg::PIX_W-1:0]  blue;

    modport source (output valid, req_type, red, green, blue, input ready);
    modport sink   (input valid, req_type, red, green, blue, output ready);
endinterface

interface dcmf_out_if;
    logic                        valid;
    logic                        ready;
    logic [dcmf_pkg::PIX_W-1:0]  dark_value;
    logic                        frame_last;

    modport source (output valid, dark_value, frame_last, input ready);
    modport sink   (input valid, dark_value, frame_last, output ready);
endinterface

// ===== rtl/dcmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dcmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dcmf_scan.sv =====
// Window walker: steps a PATCH x PATCH window over the line store, one read
// per cycle, and keeps a running minimum with one comparator. Uses dcmf_pkg.
module dcmf_scan #(
    parameter int PATCH      = dcmf_pkg::PATCH_DEF,
    parameter int MAX_WIDTH  = dcmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dcmf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [$clog2(MAX_HEIGHT)-1:0]        i_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]         i_col,
    input  logic [((PATCH > 1) ? $clog2(PATCH) : 1)-1:0] i_rowmod,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       i_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]      i_height,
    output logic                                 o_rd_en,
    output logic [$clog2(PATCH*MAX_WIDTH)-1:0]   o_rd_addr,
    input  logic [dcmf_pkg::PIX_W-1:0]           i_rd_data,
    output dcmf_pkg::t_scan_stat                 o_stat
);

    localparam int PM_W  = (PATCH > 1) ? $clog2(PATCH) : 1;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int AW    = $clog2(PATCH * MAX_WIDTH);
    localparam logic [PM_W-1:0] P_LAST = PM_W'(PATCH - 1);

    dcmf_pkg::t_scan_state r_state, n_state;

    logic [PM_W-1:0]            r_dr, r_dc, r_rowmod;
    logic [ROW_W-1:0]           r_r;
    logic [COL_W-1:0]           r_c, r_col0;
    logic [dcmf_pkg::PIX_W-1:0] r_min;
    logic                       r_rd_vld;
    logic                       row_end, win_end;

    // window clipped at the right and bottom edges (padding never lowers the min)
    assign row_end = (r_dc == P_LAST) || ((W_W'(r_c) + W_W'(1)) >= i_width);
    assign win_end = (r_dr == P_LAST) || ((H_W'(r_r) + H_W'(1)) >= i_height);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dcmf_pkg::SC_IDLE: if (i_start) n_state = dcmf_pkg::SC_READ;
            dcmf_pkg::SC_READ: if (row_end && win_end) n_state = dcmf_pkg::SC_LAST;
            dcmf_pkg::SC_LAST: n_state = dcmf_pkg::SC_FIN;
            dcmf_pkg::SC_FIN:  n_state = dcmf_pkg::SC_IDLE;
            default:           n_state = dcmf_pkg::SC_IDLE;
        endcase
    end

    always_comb begin
        o_rd_en      = (r_state == dcmf_pkg::SC_READ);
        o_rd_addr    = AW'(r_rowmod) * AW'(MAX_WIDTH) + AW'(r_c);
        o_stat.done  = (r_state == dcmf_pkg::SC_FIN);
        o_stat.value = r_min;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dcmf_pkg::SC_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == dcmf_pkg::SC_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == dcmf_pkg::SC_IDLE && i_start) begin
            r_r      <= i_row;
            r_c      <= i_col;
            r_col0   <= i_col;
            r_rowmod <= i_rowmod;
            r_dr     <= '0;
            r_dc     <= '0;
            r_min    <= dcmf_pkg::PIX_MAX;
        end else begin
            if (r_state == dcmf_pkg::SC_READ) begin
                if (row_end) begin
                    r_dc     <= '0;
                    r_c      <= r_col0;
                    r_dr     <= r_dr + PM_W'(1);
                    r_r      <= r_r + ROW_W'(1);
                    r_rowmod <= (r_rowmod == P_LAST) ? '0 : r_rowmod + PM_W'(1);
                end else begin
                    r_dc <= r_dc + PM_W'(1);
                    r_c  <= r_c + COL_W'(1);
                end
            end
            if (r_rd_vld && (i_rd_data < r_min)) begin
                r_min <= i_rd_data;
            end
        end
    end

endmodule

// ===== rtl/dark_channel_min_filter_unit.sv =====
// Dark channel minimum filter, top level: request decode, frame positions,
// line store and result register. Uses dcmf_pkg, dcmf_if, dcmf_ram, dcmf_scan.
//
// Each pixel beat is reduced to min(R,G,B) and written into a ring line store
// of PATCH rows x MAX_WIDTH entries. Results come out in raster order, trailing
// the pixels by (PATCH-1)*width + min(PATCH-1, width-1) positions; once the frame
// is in, drain beats flush the rest, one result each. A beat that produces a
// result is held up by the window walk through the single read port of the
// line store and one 8-bit comparator; input ready stays low during the walk.
// The finished result sits in an output register, so the next beat is taken
// while it waits. After reset and after every config write the input is held
// off while the frame size and lag are recomputed. A config write starts a
// new frame. The line store is not cleared; a frame only reads entries it
// wrote itself.
module dark_channel_min_filter_unit #(
    parameter int PATCH      = dcmf_pkg::PATCH_DEF,
    parameter int MAX_WIDTH  = dcmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dcmf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dcmf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dcmf_pkg::CFG_W-1:0]      i_cfg_data,
    dcmf_in_if.sink                         i_pix,
    dcmf_out_if.source                      o_dark
);

    localparam int PM_W  = (PATCH > 1) ? $clog2(PATCH) : 1;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = PATCH * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int TOT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int LAG_W = $clog2(PATCH * MAX_WIDTH + 1);
    localparam int CNT_W = (TOT_W > LAG_W) ? TOT_W : LAG_W;
    localparam int EW    = (W_W > dcmf_pkg::CFG_W) ? W_W : dcmf_pkg::CFG_W;
    localparam int EH    = (H_W > dcmf_pkg::CFG_W) ? H_W : dcmf_pkg::CFG_W;
    localparam logic [PM_W-1:0] P_LAST = PM_W'(PATCH - 1);

    dcmf_pkg::t_top_state r_state, n_state;

    // config and derived frame geometry
    logic [dcmf_pkg::CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic                       r_cfg_settle;
    logic [W_W-1:0]             eff_w, lag_col;
    logic [H_W-1:0]             eff_h;
    logic [CNT_W-1:0]           r_total, r_lag;

    // frame positions
    logic [CNT_W-1:0] r_in_pos, r_out_pos;
    logic [COL_W-1:0] r_in_col, r_out_col;
    logic [PM_W-1:0]  r_in_rowmod, r_out_rowmod;
    logic [ROW_W-1:0] r_out_row;

    // result register
    logic                       r_out_valid, r_out_last;
    logic [dcmf_pkg::PIX_W-1:0] r_out_val;

    logic                       in_ready, accept, is_pixel, pix_write, emit_now;
    logic                       scan_start, load, out_free, frame_last;
    logic                       in_col_end, out_col_end;
    logic [dcmf_pkg::PIX_W-1:0] ch_min, rg_min;
    logic [AW-1:0]              wr_addr, rd_addr;
    logic                       rd_en;
    logic [dcmf_pkg::PIX_W-1:0] rd_data;
    dcmf_pkg::t_scan_stat       scan_stat;

    // zero acts as one, oversize clamps to the store size
    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = W_W'(1);
        end else if (EW'(r_cfg_w) > EW'(MAX_WIDTH)) begin
            eff_w = W_W'(MAX_WIDTH);
        end else begin
            eff_w = W_W'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            eff_h = H_W'(1);
        end else if (EH'(r_cfg_h) > EH'(MAX_HEIGHT)) begin
            eff_h = H_W'(MAX_HEIGHT);
        end else begin
            eff_h = H_W'(r_cfg_h);
        end
        lag_col = ((eff_w - W_W'(1)) < W_W'(PATCH - 1)) ? (eff_w - W_W'(1))
                                                         : W_W'(PATCH - 1);
    end

    // request decode
    assign rg_min   = (i_pix.red < i_pix.green) ? i_pix.red : i_pix.green;
    assign ch_min   = (rg_min > i_pix.blue) ? i_pix.blue : rg_min;
    assign is_pixel = (i_pix.req_type == dcmf_pkg::REQ_PIXEL);
    assign accept   = i_pix.valid && in_ready;

    always_comb begin
        if (is_pixel) begin
            // result due once the gap after this pixel exceeds the lag
            emit_now = (r_in_pos < r_total) && (r_out_pos < r_total)
                    && ((r_in_pos - r_out_pos) >= r_lag);
        end else begin
            emit_now = (r_in_pos == r_total) && (r_out_pos < r_total);
        end
    end

    assign pix_write   = accept && is_pixel && (r_in_pos < r_total);
    assign out_free    = !r_out_valid || o_dark.ready;
    assign frame_last  = ((r_out_pos + CNT_W'(1)) == r_total);
    assign in_col_end  = ((W_W'(r_in_col) + W_W'(1)) == eff_w);
    assign out_col_end = ((W_W'(r_out_col) + W_W'(1)) == eff_w);
    assign wr_addr     = AW'(r_in_rowmod) * AW'(MAX_WIDTH) + AW'(r_in_col);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dcmf_pkg::ST_IDLE: if (accept && emit_now) n_state = dcmf_pkg::ST_SCAN;
            dcmf_pkg::ST_SCAN: if (scan_stat.done) n_state = dcmf_pkg::ST_DONE;
            dcmf_pkg::ST_DONE: if (out_free) n_state = dcmf_pkg::ST_IDLE;
            default:           n_state = dcmf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = (r_state == dcmf_pkg::ST_IDLE) && !r_cfg_settle;
        scan_start = (r_state == dcmf_pkg::ST_IDLE) && accept && emit_now;
        load       = (r_state == dcmf_pkg::ST_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dcmf_pkg::ST_IDLE;
            r_cfg_w      <= dcmf_pkg::CFG_RESET;
            r_cfg_h      <= dcmf_pkg::CFG_RESET;
            r_cfg_settle <= 1'b1;
            r_in_pos     <= '0;
            r_out_pos    <= '0;
            r_in_col     <= '0;
            r_in_rowmod  <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_out_rowmod <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cfg_settle <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (dcmf_pkg::t_cfg_reg'(i_cfg_idx))
                    dcmf_pkg::REG_WIDTH:  r_cfg_w <= i_cfg_data;
                    dcmf_pkg::REG_HEIGHT: r_cfg_h <= i_cfg_data;
                endcase
                r_in_pos     <= '0;
                r_out_pos    <= '0;
                r_in_col     <= '0;
                r_in_rowmod  <= '0;
                r_out_col    <= '0;
                r_out_row    <= '0;
                r_out_rowmod <= '0;
            end else begin
                if (pix_write) begin
                    r_in_pos <= r_in_pos + CNT_W'(1);
                    if (in_col_end) begin
                        r_in_col    <= '0;
                        r_in_rowmod <= (r_in_rowmod == P_LAST) ? '0
                                                               : r_in_rowmod + PM_W'(1);
                    end else begin
                        r_in_col <= r_in_col + COL_W'(1);
                    end
                end
                if (load) begin
                    if (frame_last) begin
                        // frame done: next pixel opens a new one
                        r_in_pos     <= '0;
                        r_out_pos    <= '0;
                        r_in_col     <= '0;
                        r_in_rowmod  <= '0;
                        r_out_col    <= '0;
                        r_out_row    <= '0;
                        r_out_rowmod <= '0;
                    end else begin
                        r_out_pos <= r_out_pos + CNT_W'(1);
                        if (out_col_end) begin
                            r_out_col    <= '0;
                            r_out_row    <= r_out_row + ROW_W'(1);
                            r_out_rowmod <= (r_out_rowmod == P_LAST) ? '0
                                                                     : r_out_rowmod + PM_W'(1);
                        end else begin
                            r_out_col <= r_out_col + COL_W'(1);
                        end
                    end
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_dark.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // geometry recomputed every cycle, registered behind the config registers
    always_ff @(posedge i_clk) begin
        r_total <= CNT_W'(TOT_W'(eff_w) * TOT_W'(eff_h));
        r_lag   <= CNT_W'(PATCH - 1) * CNT_W'(eff_w) + CNT_W'(lag_col);
        if (load) begin
            r_out_val  <= scan_stat.value;
            r_out_last <= frame_last;
        end
    end

    dcmf_ram #(
        .WIDTH (dcmf_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (pix_write),
        .i_waddr (wr_addr),
        .i_wdata (ch_min),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    dcmf_scan #(
        .PATCH      (PATCH),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_start),
        .i_row     (r_out_row),
        .i_col     (r_out_col),
        .i_rowmod  (r_out_rowmod),
        .i_width   (eff_w),
        .i_height  (eff_h),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_stat    (scan_stat)
    );

    assign i_pix.ready       = in_ready;
    assign o_dark.valid      = r_out_valid;
    assign o_dark.dark_value = r_out_val;
    assign o_dark.frame_last = r_out_last;

    // outputs never run ahead of the pixels taken in
    a_out_behind_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_pos <= r_in_pos)
        else $error("output position ahead of input position");

    // input position stays within the frame once geometry has settled
    a_in_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cfg_settle |-> r_in_pos <= r_total)
        else $error("input position past frame size");

    // window walk completes only for a pending result
    a_scan_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_stat.done |-> r_state == dcmf_pkg::ST_SCAN)
        else $error("window walk finished outside a scan");

    // a finished result waits until the output register frees up
    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dcmf_pkg::ST_DONE && !out_free) |=> r_state == dcmf_pkg::ST_DONE)
        else $error("result dropped while output register busy");

endmodule
